// ----- rtl/cfsd_pkg.sv -----
// ----------------------------------------------------------------------------
// cfsd_pkg: shared definitions for the cross-feedback stereo delay
// Default sizes, configuration register indexes, reset values and the
// fixed-point constants used by the datapath.
// ----------------------------------------------------------------------------
package cfsd_pkg;

  localparam int CFSD_HISTORY_DEPTH = 65536;
  localparam int CFSD_SAMPLE_BITS   = 24;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RTL_FEEDBACK   = 3'd0,
    CFG_LTR_FEEDBACK   = 3'd1,
    CFG_RTL_DELAY      = 3'd2,
    CFG_LTR_DELAY      = 3'd3,
    CFG_LOWPASS_RETAIN = 3'd4
  } cfg_reg_t;

  localparam logic signed [15:0] RST_RTL_FEEDBACK   = -16'sd11469;
  localparam logic signed [15:0] RST_LTR_FEEDBACK   = 16'sd9830;
  localparam logic        [15:0] RST_RTL_DELAY      = 16'd12480;
  localparam logic        [15:0] RST_LTR_DELAY      = 16'd4320;
  localparam logic        [15:0] RST_LOWPASS_RETAIN = 16'd54200;

  // Unity in Q2.14 and unity in Q0.16 (the latter needs 17 bits).
  localparam logic signed [15:0] FB_ONE   = 16'sd16384;
  localparam logic        [16:0] COEF_ONE = 17'd65536;

endpackage

// ----- rtl/cfsd_in_if.sv -----
// ----------------------------------------------------------------------------
// cfsd_in_if: stereo input sample channel
// Valid/ready channel carrying one left/right input pair per transfer.
// ----------------------------------------------------------------------------
interface cfsd_in_if
  import cfsd_pkg::*;
#(
  parameter int SAMPLE_BITS = CFSD_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

// ----- rtl/cfsd_out_if.sv -----
// ----------------------------------------------------------------------------
// cfsd_out_if: stereo result channel
// Valid/ready channel carrying one left/right result pair per transfer.
// ----------------------------------------------------------------------------
interface cfsd_out_if
  import cfsd_pkg::*;
#(
  parameter int SAMPLE_BITS = CFSD_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_result;
  logic signed [SAMPLE_BITS-1:0] right_result;

  modport source (output valid, left_result, right_result, input ready);
  modport sink   (input valid, left_result, right_result, output ready);
endinterface

// ----- rtl/cfsd_ram.sv -----
// ----------------------------------------------------------------------------
// cfsd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cfsd_ram
  import cfsd_pkg::*;
#(
  parameter int WIDTH = CFSD_SAMPLE_BITS,
  parameter int DEPTH = CFSD_HISTORY_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cross_feedback_stereo_delay.sv -----
// ----------------------------------------------------------------------------
// cross_feedback_stereo_delay: stereo delay with cross feedback and low-pass
// Each stereo pair is mixed with the opposite channel's delayed output, then
// smoothed by a one-pole low-pass and saturated to symmetric full scale.
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries one left/right sample pair per transfer; out_ch returns one
//   filtered left/right pair per input transfer, in order. cfg_we, cfg_index
//   and cfg_wdata write the five coefficient registers; unknown indexes are
//   ignored. The user makes writes only while the block is idle (not enforced).
// Operation
//   After its input transfer, each pair runs through a bit-serial feedback
//   mix, then a bit-serial low-pass, then a write-back, with the history
//   read on the accepting edge. One item is in flight at a time, so a new
//   pair is taken only after the last one has been written back.
// Reset
//   Registers take their default values, the filter states and write pointer
//   clear, and the histories read as zero: a fill marker (write pointer plus
//   a wrapped flag) masks entries not yet written, so no clearing pass runs.
// Stalls
//   The result sits in an output register. A new input transfer is taken
//   while it waits; the write-back of that next item waits until the held
//   result has been transferred. HISTORY_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module cross_feedback_stereo_delay
  import cfsd_pkg::*;
#(
  parameter int HISTORY_DEPTH = CFSD_HISTORY_DEPTH,
  parameter int SAMPLE_BITS   = CFSD_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  cfsd_in_if.sink                   in_ch,
  cfsd_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(HISTORY_DEPTH);
  // Width for pointer arithmetic: wide enough for both pointer and delay.
  localparam int CW  = (AW > 16) ? AW : 16;
  // Mix accumulator: x*(1-|fb|) + h*fb in Q.14 plus headroom.
  localparam int MAW = SB + 17;
  // Mix value after the Q.14 truncation.
  localparam int MXW = SB + 3;
  // Filter accumulator: state*retain + mix*(1-retain) in Q.16 plus headroom.
  localparam int FAW = SB + 21;
  localparam int YW  = FAW - 16;
  localparam int MIX_STEPS  = 16;
  localparam int FILT_STEPS = 17;

  localparam logic signed [YW-1:0] LIM_P = YW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [YW-1:0] LIM_N = -LIM_P;

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_FILT, S_DONE} state_t;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic signed [15:0] rtl_feedback_r, ltr_feedback_r;
  logic        [15:0] rtl_delay_r, ltr_delay_r, lowpass_retain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtl_feedback_r   <= RST_RTL_FEEDBACK;
      ltr_feedback_r   <= RST_LTR_FEEDBACK;
      rtl_delay_r      <= RST_RTL_DELAY;
      ltr_delay_r      <= RST_LTR_DELAY;
      lowpass_retain_r <= RST_LOWPASS_RETAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RTL_FEEDBACK:   rtl_feedback_r   <= cfg_wdata;
        CFG_LTR_FEEDBACK:   ltr_feedback_r   <= cfg_wdata;
        CFG_RTL_DELAY:      rtl_delay_r      <= cfg_wdata;
        CFG_LTR_DELAY:      ltr_delay_r      <= cfg_wdata;
        CFG_LOWPASS_RETAIN: lowpass_retain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state.
  // --------------------------------------------------------------------------
  state_t          state_r;
  logic [4:0]      cnt_r;
  logic [AW-1:0]   wi_r;
  logic            wrapped_r;
  logic            out_valid_r;
  logic signed [SB-1:0] out_left_r, out_right_r;

  logic in_fire, done_fire;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign done_fire   = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // --------------------------------------------------------------------------
  // History read addresses and the fill marker. Lane 0 is left and reads the
  // right history at the right-to-left delay; lane 1 is the mirror image.
  // --------------------------------------------------------------------------
  logic [CW-1:0] rd_diff_l, rd_diff_r;
  logic [AW-1:0] raddr_l, raddr_r;   // address into left / right history

  assign rd_diff_r = CW'(wi_r) - CW'(rtl_delay_r);
  assign rd_diff_l = CW'(wi_r) - CW'(ltr_delay_r);
  assign raddr_r   = rd_diff_r[AW-1:0];
  assign raddr_l   = rd_diff_l[AW-1:0];

  logic [SB-1:0] rdata_l, rdata_r;
  logic [SB-1:0] y_l, y_r;

  cfsd_ram #(.WIDTH(SB), .DEPTH(HISTORY_DEPTH)) u_left_hist (
    .clk   (clk),
    .we    (done_fire),
    .waddr (wi_r),
    .wdata (y_l),
    .re    (in_fire),
    .raddr (raddr_l),
    .rdata (rdata_l)
  );

  cfsd_ram #(.WIDTH(SB), .DEPTH(HISTORY_DEPTH)) u_right_hist (
    .clk   (clk),
    .we    (done_fire),
    .waddr (wi_r),
    .wdata (y_r),
    .re    (in_fire),
    .raddr (raddr_r),
    .rdata (rdata_r)
  );

  // --------------------------------------------------------------------------
  // Datapath, one lane per channel. The coefficients sit in shift registers
  // and are consumed most significant bit first, so each multiply becomes a
  // Horner loop of shift and conditional add.
  // --------------------------------------------------------------------------
  logic signed [SB-1:0]  x_r     [2];
  logic                  hval_r  [2];
  logic [15:0]           a_sr_r  [2];   // 1 - |fb|, unsigned
  logic [15:0]           fb_sr_r [2];   // clamped feedback, two's complement
  logic [16:0]           w_sr_r;        // 1 - retain
  logic [16:0]           rt_sr_r;       // retain
  logic signed [MAW-1:0] macc_r  [2];
  logic signed [MXW-1:0] mix_r   [2];
  logic signed [FAW-1:0] facc_r  [2];
  logic signed [SB-1:0]  st_r    [2];

  logic signed [15:0]    fb_raw  [2];
  logic signed [15:0]    fb_c    [2];
  logic [15:0]           a_c     [2];
  logic signed [SB-1:0]  h       [2];
  logic signed [SB-1:0]  samp    [2];
  logic                  hval_nxt[2];
  logic signed [MAW-1:0] macc_nxt[2];
  logic signed [MAW-1:0] mterm_x [2];
  logic signed [MAW-1:0] mterm_h [2];
  logic signed [FAW-1:0] facc_nxt[2];
  logic signed [FAW-1:0] fterm_m [2];
  logic signed [FAW-1:0] fterm_s [2];
  logic signed [YW-1:0]  yfull   [2];
  logic signed [SB-1:0]  ysat    [2];
  logic                  first_mix;

  assign fb_raw[0] = rtl_feedback_r;
  assign fb_raw[1] = ltr_feedback_r;
  assign samp[0]   = in_ch.left_sample;
  assign samp[1]   = in_ch.right_sample;
  assign h[0]      = hval_r[0] ? $signed(rdata_r) : '0;
  assign h[1]      = hval_r[1] ? $signed(rdata_l) : '0;
  assign hval_nxt[0] = wrapped_r || (raddr_r < wi_r);
  assign hval_nxt[1] = wrapped_r || (raddr_l < wi_r);
  // The feedback bit of weight minus 2^15 comes first.
  assign first_mix = (cnt_r == 5'(MIX_STEPS - 1));

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      // Feedback is clamped to +-1.0 before use.
      if (fb_raw[c] > FB_ONE) begin
        fb_c[c] = FB_ONE;
      end else if (fb_raw[c] < -FB_ONE) begin
        fb_c[c] = -FB_ONE;
      end else begin
        fb_c[c] = fb_raw[c];
      end
      a_c[c] = (fb_c[c] < 0) ? 16'(FB_ONE + fb_c[c]) : 16'(FB_ONE - fb_c[c]);

      mterm_x[c] = a_sr_r[c][15] ? MAW'(x_r[c]) : '0;
      if (!fb_sr_r[c][15]) begin
        mterm_h[c] = '0;
      end else if (first_mix) begin
        mterm_h[c] = -MAW'(h[c]);
      end else begin
        mterm_h[c] = MAW'(h[c]);
      end
      macc_nxt[c] = (macc_r[c] <<< 1) + mterm_x[c] + mterm_h[c];

      fterm_m[c]  = w_sr_r[16]  ? FAW'(mix_r[c]) : '0;
      fterm_s[c]  = rt_sr_r[16] ? FAW'(st_r[c])  : '0;
      facc_nxt[c] = (facc_r[c] <<< 1) + fterm_m[c] + fterm_s[c];

      yfull[c] = YW'(facc_r[c] >>> 16);
      if (yfull[c] > LIM_P) begin
        ysat[c] = SB'(LIM_P);
      end else if (yfull[c] < LIM_N) begin
        ysat[c] = SB'(LIM_N);
      end else begin
        ysat[c] = SB'(yfull[c]);
      end
    end
  end

  assign y_l = ysat[0];
  assign y_r = ysat[1];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_sr_r  <= COEF_ONE - 17'(lowpass_retain_r);
      rt_sr_r <= 17'(lowpass_retain_r);
    end else if (state_r == S_FILT) begin
      w_sr_r  <= w_sr_r << 1;
      rt_sr_r <= rt_sr_r << 1;
    end
    for (int c = 0; c < 2; c++) begin
      if (in_fire) begin
        x_r[c]     <= samp[c];
        hval_r[c]  <= hval_nxt[c];
        a_sr_r[c]  <= a_c[c];
        fb_sr_r[c] <= fb_c[c];
        macc_r[c]  <= '0;
        facc_r[c]  <= '0;
      end else if (state_r == S_MIX) begin
        a_sr_r[c]  <= a_sr_r[c] << 1;
        fb_sr_r[c] <= fb_sr_r[c] << 1;
        macc_r[c]  <= macc_nxt[c];
      end else if (state_r == S_FILT) begin
        facc_r[c]  <= facc_nxt[c];
      end
      // The mix is taken once the last mix step has landed.
      if (state_r == S_MIX && cnt_r == '0) begin
        mix_r[c] <= MXW'(macc_nxt[c] >>> 14);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer, filter states, write pointer and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wi_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r[0]     <= '0;
      st_r[1]     <= '0;
    end else begin
      // A fresh result replaces one that is transferred at the same edge.
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_MIX;
            cnt_r   <= 5'(MIX_STEPS - 1);
          end
        end
        S_MIX: begin
          if (cnt_r == '0) begin
            state_r <= S_FILT;
            cnt_r   <= 5'(FILT_STEPS - 1);
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_FILT: begin
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            state_r     <= S_IDLE;
            out_left_r  <= ysat[0];
            out_right_r <= ysat[1];
            st_r[0]     <= ysat[0];
            st_r[1]     <= ysat[1];
            wi_r        <= wi_r + 1'b1;
            if (&wi_r) begin
              wrapped_r <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.left_result  = out_left_r;
  assign out_ch.right_result = out_right_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_accept_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MIX && cnt_r == 5'(MIX_STEPS - 1)))
    else $error("accepted transfer did not start the mix loop");

  a_ptr_moves_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    (wi_r != $past(wi_r)) |-> (out_valid_r && $past(done_fire)))
    else $error("write pointer moved without a result");

  a_result_advances_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> (wi_r == AW'($past(wi_r) + 1'b1)))
    else $error("write pointer did not advance after write-back");

  a_result_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r != SB'(LIM_N - 1'b1) && out_right_r != SB'(LIM_N - 1'b1)))
    else $error("result outside symmetric full scale");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for cross_feedback_stereo_delay
// Stereo pairs are sent through the input channel with random gaps. Each
// accepted transfer is run through a local model of the delay lines,
// cross-feedback mix and low-pass. The expected pair is queued and compared
// with the result channel, which also stalls at random. The coefficient
// registers are rewritten between phases, including the out-of-range cases.
// ----------------------------------------------------------------------------
module tb;
  import cfsd_pkg::*;

  localparam int DEPTH      = CFSD_HISTORY_DEPTH;
  localparam int SBITS      = CFSD_SAMPLE_BITS;
  localparam int LATENCY    = 40;   // one item's processing time, plus a margin
  localparam int RANDOM_PHASES = 8;
  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LAST  = 3'd7;
  localparam longint FULL_SCALE = (64'sd1 <<< (SBITS - 1)) - 1;

  typedef struct {
    logic signed [SBITS-1:0] left;
    logic signed [SBITS-1:0] right;
  } stereo_pair_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  cfsd_in_if  in_ch ();
  cfsd_out_if out_ch ();

  cross_feedback_stereo_delay dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the block's state and registers.
  logic [15:0] gain_rl, gain_lr, delay_rl, delay_lr, retain;
  logic signed [SBITS-1:0] hist_left  [DEPTH];
  logic signed [SBITS-1:0] hist_right [DEPTH];
  logic [15:0] wr_ptr;
  longint lp_left, lp_right;

  stereo_pair_t sample_queue[$];    // pairs waiting to be offered
  stereo_pair_t expected_pairs[$];  // pairs predicted, not yet seen
  int errors;
  int results_seen;
  bit no_gaps;        // sender and receiver run flat out
  int long_hold;      // cycles the receiver is to hold off in one stretch

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2000000);
    $display("Timeout with %0d results outstanding", expected_pairs.size());
    $display("TEST FAILED");
    $finish;
  end

  // Clamp a Q2.14 gain to plus or minus unity.
  function automatic longint clamp_gain(logic [15:0] raw);
    longint g;
    g = longint'($signed(raw));
    if (g > 16384) g = 16384;
    if (g < -16384) g = -16384;
    return g;
  endfunction

  // One channel: feedback mix, one-pole low-pass, symmetric saturation.
  // Arithmetic right shifts of signed values give the floor division.
  function automatic longint mix_and_smooth(longint x, longint h, longint g, longint st);
    longint ag, mix, y, r;
    ag  = (g < 0) ? -g : g;
    mix = (x * (16384 - ag) + h * g) >>> 14;
    r   = longint'(retain);
    y   = (st * r + mix * (65536 - r)) >>> 16;
    if (y > FULL_SCALE) y = FULL_SCALE;
    if (y < -FULL_SCALE) y = -FULL_SCALE;
    return y;
  endfunction

  // Advance the model by one accepted pair and queue the expected result.
  // Both histories are read before either is written.
  function automatic void delay_line_step(stereo_pair_t s);
    logic [15:0] rd_rl, rd_lr;
    longint hr, hl, yl, yr;
    stereo_pair_t res;
    rd_rl = wr_ptr - delay_rl;
    rd_lr = wr_ptr - delay_lr;
    hr = longint'(hist_right[rd_rl]);
    hl = longint'(hist_left[rd_lr]);
    yl = mix_and_smooth(longint'(s.left),  hr, clamp_gain(gain_rl), lp_left);
    yr = mix_and_smooth(longint'(s.right), hl, clamp_gain(gain_lr), lp_right);
    lp_left  = yl;
    lp_right = yr;
    hist_left[wr_ptr]  = yl[SBITS-1:0];
    hist_right[wr_ptr] = yr[SBITS-1:0];
    wr_ptr = wr_ptr + 16'd1;
    res.left  = yl[SBITS-1:0];
    res.right = yr[SBITS-1:0];
    expected_pairs.push_back(res);
  endfunction

  // Sender: offers queued pairs, with a random gap before each unless the
  // phase runs without gaps. Valid is written once per edge.
  int send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.left_sample <= '0;
      in_ch.right_sample <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        delay_line_step('{in_ch.left_sample, in_ch.right_sample});
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          stereo_pair_t nxt;
          nxt = sample_queue.pop_front();
          in_ch.left_sample  <= nxt.left;
          in_ch.right_sample <= nxt.right;
          in_ch.valid <= 1'b1;
          send_gap <= no_gaps ? 0 : $urandom_range(0, 3);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every transfer against the oldest expectation, stalls
  // at random after each, and honours a long hold-off when one is requested.
  int recv_stall;
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected result L=%0d R=%0d", $time,
                   out_ch.left_result, out_ch.right_result);
          errors = errors + 1;
        end else begin
          stereo_pair_t exp_pair;
          exp_pair = expected_pairs.pop_front();
          if (exp_pair.left !== out_ch.left_result) begin
            $display("%0t: left_result expected %0d, got %0d", $time,
                     exp_pair.left, out_ch.left_result);
            errors = errors + 1;
          end
          if (exp_pair.right !== out_ch.right_result) begin
            $display("%0t: right_result expected %0d, got %0d", $time,
                     exp_pair.right, out_ch.right_result);
            errors = errors + 1;
          end
        end
      end
      if (long_hold != 0) begin
        hold_left <= long_hold;
        long_hold <= 0;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        // After every transfer a fresh random stall is drawn, unless the phase runs without gaps.
        if (no_gaps) begin
          out_ch.ready <= 1'b1;
        end else begin
          int stall;
          stall = $urandom_range(0, 3);
          recv_stall <= (stall == 0) ? 0 : stall - 1;
          out_ch.ready <= (stall == 0);
        end
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Register write: the local copy is updated as soon as the write is driven, before the block's register takes it.
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RTL_FEEDBACK:   gain_rl  = val;
      CFG_LTR_FEEDBACK:   gain_lr  = val;
      CFG_RTL_DELAY:      delay_rl = val;
      CFG_LTR_DELAY:      delay_lr = val;
      CFG_LOWPASS_RETAIN: retain   = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(logic [15:0] g_rl, logic [15:0] g_lr, logic [15:0] d_rl,
                         logic [15:0] d_lr, logic [15:0] ret);
    write_reg(CFG_RTL_FEEDBACK, g_rl);
    write_reg(CFG_LTR_FEEDBACK, g_lr);
    write_reg(CFG_RTL_DELAY, d_rl);
    write_reg(CFG_LTR_DELAY, d_lr);
    write_reg(CFG_LOWPASS_RETAIN, ret);
  endtask

  // Waits until every queued pair has been sent and answered, then lets the
  // pipeline settle before the registers are touched again. The queues are
  // looked at on the falling edge, clear of the clocked processes.
  task automatic drain();
    do
      @(negedge clk);
    while (sample_queue.size() != 0 || expected_pairs.size() != 0 || in_ch.valid);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [SBITS-1:0] any_sample(bit quiet);
    if (quiet) return SBITS'($signed($urandom_range(0, 4000)) - 2000);
    return SBITS'($urandom);
  endfunction

  task automatic queue_random(int n);
    bit quiet;
    for (int i = 0; i < n; i++) begin
      quiet = ($urandom_range(0, 3) == 0);
      sample_queue.push_back('{any_sample(quiet), any_sample(quiet)});
    end
  endtask

  logic signed [SBITS-1:0] edge_vals[6];

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_RTL_FEEDBACK;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    results_seen = 0;
    no_gaps = 1'b0;
    long_hold = 0;
    gain_rl  = RST_RTL_FEEDBACK;
    gain_lr  = RST_LTR_FEEDBACK;
    delay_rl = RST_RTL_DELAY;
    delay_lr = RST_LTR_DELAY;
    retain   = RST_LOWPASS_RETAIN;
    wr_ptr = '0;
    lp_left = 0;
    lp_right = 0;
    for (int i = 0; i < DEPTH; i++) begin
      hist_left[i] = '0;
      hist_right[i] = '0;
    end
    edge_vals = '{24'sh7FFFFF, -24'sh800000, 24'sd0, 24'sd1, -24'sd1, -24'sh7FFFFF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients first, pairing each field extreme with itself and with its mirror in the list.
    foreach (edge_vals[i]) begin
      sample_queue.push_back('{edge_vals[i], edge_vals[5 - i]});
      sample_queue.push_back('{edge_vals[i], edge_vals[i]});
    end
    drain();

    // Full feedback both ways, one-sample delays, filter bypassed: the
    // outputs swing hard against saturation.
    set_all(16'sd16384, -16'sd16384, 16'd1, 16'd1, 16'd0);
    foreach (edge_vals[i]) sample_queue.push_back('{edge_vals[i], edge_vals[i]});
    drain();

    // Gains beyond unity are clamped; zero delay reads the slot being
    // replaced; the heaviest smoothing. Spare indexes must change nothing.
    set_all(16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'hFFFF);
    for (int k = int'(CFG_SPARE_FIRST); k <= int'(CFG_SPARE_LAST); k++) begin
      write_reg(CFG_INDEX_BITS'(k), 16'($urandom));
    end
    queue_random(6);
    drain();

    // Longest delays, gaps switched off for a stretch.
    no_gaps = 1'b1;
    set_all(-16'sd16384, 16'sd16384, 16'hFFFF, 16'hFFFE, 16'd1);
    queue_random(200);
    drain();
    no_gaps = 1'b0;

    // Random settings with short delays so the cross feedback builds up.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_all(($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384),
              ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384),
              16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
              16'($urandom_range(0, 65535)));
      no_gaps = (p == 3);
      queue_random(150);
      // Receiver holds off long enough for the block to back up its input.
      if (p == 1) long_hold = 400;
      drain();
    end

    $display("Checked %0d stereo results over %0d register settings, including clamped",
             results_seen, RANDOM_PHASES + 4);
    $display("gains, zero and maximum delays, filter bypass and a long output stall.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
